[rtl/srts_pkg.sv]
// ----------------------------------------------------------------------------
// srts_pkg
// Shared types, constants and codes of the signed radix to symbols converter.
// ----------------------------------------------------------------------------
package srts_pkg;

    localparam int MAX_RADIX   = 16;
    localparam int VALUE_WIDTH = 32;
    localparam int IN_DATA_W   = ((VALUE_WIDTH + 7) / 8) * 8;

    // Dividend bits consumed by the divider in one cycle.
    localparam int STEP_W      = 4;
    localparam int NIBBLES     = (VALUE_WIDTH + STEP_W - 1) / STEP_W;
    localparam int MAG_W       = NIBBLES * STEP_W;
    localparam int CNT_W       = $clog2(NIBBLES);

    localparam int RADIX_W     = 5;
    localparam int DIGIT_W     = $clog2(MAX_RADIX);
    localparam int X_W         = DIGIT_W + STEP_W + 1;

    localparam int MAX_DIGITS  = VALUE_WIDTH;
    localparam int STK_CNT_W   = $clog2(MAX_DIGITS + 1);

    localparam int SYM_W       = 8;
    localparam int CFG_W       = 64;
    localparam int ALPHA_W     = 2 * CFG_W;
    localparam int CFG_IDX_W   = 2;

    localparam logic [SYM_W-1:0] CHAR_PLUS  = 8'h2B;
    localparam logic [SYM_W-1:0] CHAR_MINUS = 8'h2D;
    localparam logic [SYM_W-1:0] CHAR_ZERO  = 8'h30;
    localparam logic [SYM_W-1:0] CHAR_LOW   = 8'd32;
    localparam logic [SYM_W-1:0] CHAR_HIGH  = 8'd127;

    localparam logic [CFG_IDX_W-1:0] REG_RADIX        = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_SYMBOLS_LOW  = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_SYMBOLS_HIGH = 2'd2;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_DIV,
        ST_SIGN,
        ST_DIGITS,
        ST_ZERO
    } srts_state_t;

    typedef struct packed {
        logic load;
        logic cont;
    } div_ctrl_t;

    typedef struct packed {
        logic               done;
        logic               quo_zero;
        logic [DIGIT_W-1:0] digit;
    } div_stat_t;

    typedef struct packed {
        logic push;
        logic pop;
    } stk_ctrl_t;

endpackage

[rtl/srts_alpha_check.sv]
// ----------------------------------------------------------------------------
// srts_alpha_check
// Decides whether the configured alphabet is usable for conversion.
// ----------------------------------------------------------------------------
module srts_alpha_check
(
    input  logic [srts_pkg::RADIX_W-1:0] radix_eff,
    input  logic [srts_pkg::ALPHA_W-1:0] alphabet,
    output logic                         ok
);

    logic [srts_pkg::MAX_RADIX-1:0] in_use;
    logic                           bad;

    always_comb
    begin
        logic [srts_pkg::SYM_W-1:0] ci;
        logic [srts_pkg::SYM_W-1:0] cj;
        bad = 1'b0;
        for (int i = 0; i < srts_pkg::MAX_RADIX; i++)
        begin
            in_use[i] = (srts_pkg::RADIX_W'(i) < radix_eff);
        end
        for (int i = 0; i < srts_pkg::MAX_RADIX; i++)
        begin
            ci = alphabet[i*srts_pkg::SYM_W +: srts_pkg::SYM_W];
            if (in_use[i] && (ci == srts_pkg::CHAR_PLUS || ci == srts_pkg::CHAR_MINUS
                              || ci <= srts_pkg::CHAR_LOW || ci >= srts_pkg::CHAR_HIGH))
            begin
                bad = 1'b1;
            end
            for (int j = i + 1; j < srts_pkg::MAX_RADIX; j++)
            begin
                cj = alphabet[j*srts_pkg::SYM_W +: srts_pkg::SYM_W];
                // A later symbol in use implies the earlier one is in use too.
                if (in_use[j] && ci == cj)
                begin
                    bad = 1'b1;
                end
            end
        end
        ok = (radix_eff >= srts_pkg::RADIX_W'(2)) && !bad;
    end

endmodule

[rtl/srts_divider.sv]
// ----------------------------------------------------------------------------
// srts_divider
// Divides the magnitude by the radix, one four-bit digit of dividend a cycle.
// ----------------------------------------------------------------------------
module srts_divider
(
    input  logic                         clk,
    input  logic                         rst_n,
    input  srts_pkg::div_ctrl_t          ctrl,
    input  logic [srts_pkg::MAG_W-1:0]   mag,
    input  logic [srts_pkg::RADIX_W-1:0] radix_eff,
    output srts_pkg::div_stat_t          stat
);

    logic [srts_pkg::MAG_W-1:0]   q_reg;
    logic [srts_pkg::MAG_W-1:0]   q_next;
    logic [srts_pkg::DIGIT_W-1:0] rem_reg;
    logic [srts_pkg::CNT_W-1:0]   cnt_reg;
    logic                         busy_reg;
    logic [srts_pkg::X_W-1:0]     x_rem;
    logic [srts_pkg::STEP_W-1:0]  q_step;
    logic                         done;

    // Restoring division of {remainder, next dividend digit} by the radix.
    always_comb
    begin
        logic [srts_pkg::X_W-1:0] trial;
        x_rem = srts_pkg::X_W'({rem_reg, q_reg[srts_pkg::MAG_W-1 -: srts_pkg::STEP_W]});
        for (int k = srts_pkg::STEP_W - 1; k >= 0; k--)
        begin
            trial = srts_pkg::X_W'(radix_eff) << k;
            q_step[k] = (x_rem >= trial);
            if (q_step[k])
            begin
                x_rem = x_rem - trial;
            end
        end
    end

    assign q_next        = {q_reg[srts_pkg::MAG_W-srts_pkg::STEP_W-1:0], q_step};
    assign done          = busy_reg && (cnt_reg == srts_pkg::CNT_W'(srts_pkg::NIBBLES - 1));
    assign stat.done     = done;
    assign stat.quo_zero = (q_next == '0);
    assign stat.digit    = x_rem[srts_pkg::DIGIT_W-1:0];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else if (ctrl.load)
        begin
            busy_reg <= 1'b1;
            cnt_reg  <= '0;
        end
        else if (busy_reg)
        begin
            if (done)
            begin
                busy_reg <= ctrl.cont;
                cnt_reg  <= '0;
            end
            else
            begin
                cnt_reg <= cnt_reg + srts_pkg::CNT_W'(1);
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctrl.load)
        begin
            q_reg   <= mag;
            rem_reg <= '0;
        end
        else if (busy_reg)
        begin
            q_reg   <= q_next;
            rem_reg <= done ? '0 : stat.digit;
        end
    end

endmodule

[rtl/srts_digit_stack.sv]
// ----------------------------------------------------------------------------
// srts_digit_stack
// Last-in first-out shift line that reverses the digit order for output.
// ----------------------------------------------------------------------------
module srts_digit_stack
(
    input  logic                           clk,
    input  logic                           rst_n,
    input  srts_pkg::stk_ctrl_t            ctrl,
    input  logic [srts_pkg::DIGIT_W-1:0]   push_digit,
    output logic [srts_pkg::DIGIT_W-1:0]   top,
    output logic [srts_pkg::STK_CNT_W-1:0] count
);

    logic [srts_pkg::DIGIT_W-1:0]   stk_reg [srts_pkg::MAX_DIGITS];
    logic [srts_pkg::STK_CNT_W-1:0] cnt_reg;

    assign top   = stk_reg[0];
    assign count = cnt_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg <= '0;
        end
        else if (ctrl.push)
        begin
            cnt_reg <= cnt_reg + srts_pkg::STK_CNT_W'(1);
        end
        else if (ctrl.pop)
        begin
            cnt_reg <= cnt_reg - srts_pkg::STK_CNT_W'(1);
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctrl.push)
        begin
            stk_reg[0] <= push_digit;
            for (int i = 1; i < srts_pkg::MAX_DIGITS; i++)
            begin
                stk_reg[i] <= stk_reg[i-1];
            end
        end
        else if (ctrl.pop)
        begin
            for (int i = 0; i < srts_pkg::MAX_DIGITS - 1; i++)
            begin
                stk_reg[i] <= stk_reg[i+1];
            end
        end
    end

endmodule

[rtl/signed_radix_to_symbols.sv]
// ----------------------------------------------------------------------------
// signed_radix_to_symbols
// Each digit of a value takes a full pass of the divider (one four-bit
// step of the 32-bit magnitude a cycle); digits are stacked and emitted
// in reverse, led by a minus sign for a negative value. A new value is
// taken only in the idle state and output stalls hold the sequencer.
// rst_n clears the configuration registers to zero, so nothing is
// emitted until a valid alphabet is written.
// ----------------------------------------------------------------------------
module signed_radix_to_symbols
(
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           cfg_valid,
    output logic                           cfg_ready,
    input  logic [srts_pkg::CFG_IDX_W-1:0] cfg_index,
    input  logic [srts_pkg::CFG_W-1:0]     cfg_data,
    input  logic                           s_axis_tvalid,
    output logic                           s_axis_tready,
    input  logic [srts_pkg::IN_DATA_W-1:0] s_axis_tdata,   // [31:0] value
    output logic                           m_axis_tvalid,
    input  logic                           m_axis_tready,
    output logic [srts_pkg::SYM_W-1:0]     m_axis_tdata,   // [7:0] symbol
    output logic                           m_axis_tlast    // last
);

    srts_pkg::srts_state_t          state_reg;
    srts_pkg::srts_state_t          state_next;
    logic [srts_pkg::RADIX_W-1:0]   radix_reg;
    logic [srts_pkg::CFG_W-1:0]     sym_low_reg;
    logic [srts_pkg::CFG_W-1:0]     sym_high_reg;
    logic [srts_pkg::RADIX_W-1:0]   radix_eff;
    logic [srts_pkg::ALPHA_W-1:0]   alphabet;
    logic                           alpha_ok;
    logic                           neg_reg;
    logic [srts_pkg::VALUE_WIDTH-1:0] in_value;
    logic [srts_pkg::VALUE_WIDTH-1:0] value_abs;
    logic [srts_pkg::MAG_W-1:0]     mag;
    srts_pkg::div_ctrl_t            div_ctrl;
    srts_pkg::div_stat_t            div_stat;
    srts_pkg::stk_ctrl_t            stk_ctrl;
    logic [srts_pkg::DIGIT_W-1:0]   stk_top;
    logic [srts_pkg::STK_CNT_W-1:0] stk_count;
    logic                           in_xfer;
    logic                           out_free;
    logic                           out_load;
    logic [srts_pkg::SYM_W-1:0]     out_sym;
    logic                           out_last;
    logic                           out_valid_reg;
    logic [srts_pkg::SYM_W-1:0]     out_sym_reg;
    logic                           out_last_reg;

    // ---------------- configuration ----------------
    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            radix_reg    <= '0;
            sym_low_reg  <= '0;
            sym_high_reg <= '0;
        end
        else if (cfg_valid)
        begin
            case (cfg_index)
                srts_pkg::REG_RADIX:        radix_reg    <= cfg_data[srts_pkg::RADIX_W-1:0];
                srts_pkg::REG_SYMBOLS_LOW:  sym_low_reg  <= cfg_data;
                srts_pkg::REG_SYMBOLS_HIGH: sym_high_reg <= cfg_data;
                default:                    ;
            endcase
        end
    end

    assign radix_eff = (radix_reg > srts_pkg::RADIX_W'(srts_pkg::MAX_RADIX))
                     ? srts_pkg::RADIX_W'(srts_pkg::MAX_RADIX) : radix_reg;
    assign alphabet  = {sym_high_reg, sym_low_reg};

    srts_alpha_check u_check
    (
        .radix_eff (radix_eff),
        .alphabet  (alphabet),
        .ok        (alpha_ok)
    );

    // ---------------- datapath ----------------
    assign in_xfer   = s_axis_tvalid && s_axis_tready;
    assign in_value  = s_axis_tdata[srts_pkg::VALUE_WIDTH-1:0];
    // The most negative value negates to itself, which reads correctly as unsigned.
    assign value_abs = in_value[srts_pkg::VALUE_WIDTH-1]
                     ? (srts_pkg::VALUE_WIDTH'(0) - in_value) : in_value;
    assign mag       = srts_pkg::MAG_W'(value_abs);

    always_ff @(posedge clk)
    begin
        if (in_xfer)
        begin
            neg_reg <= in_value[srts_pkg::VALUE_WIDTH-1];
        end
    end

    srts_divider u_div
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .ctrl      (div_ctrl),
        .mag       (mag),
        .radix_eff (radix_eff),
        .stat      (div_stat)
    );

    srts_digit_stack u_stack
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .ctrl       (stk_ctrl),
        .push_digit (div_stat.digit),
        .top        (stk_top),
        .count      (stk_count)
    );

    // ---------------- sequencer ----------------
    assign out_free = !out_valid_reg || m_axis_tready;

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            srts_pkg::ST_IDLE:
            begin
                if (s_axis_tvalid && alpha_ok)
                begin
                    state_next = (in_value == '0) ? srts_pkg::ST_ZERO : srts_pkg::ST_DIV;
                end
            end
            srts_pkg::ST_DIV:
            begin
                if (div_stat.done && div_stat.quo_zero)
                begin
                    state_next = neg_reg ? srts_pkg::ST_SIGN : srts_pkg::ST_DIGITS;
                end
            end
            srts_pkg::ST_SIGN:
            begin
                if (out_free)
                begin
                    state_next = srts_pkg::ST_DIGITS;
                end
            end
            srts_pkg::ST_DIGITS:
            begin
                if (out_free && stk_count == srts_pkg::STK_CNT_W'(1))
                begin
                    state_next = srts_pkg::ST_IDLE;
                end
            end
            srts_pkg::ST_ZERO:
            begin
                if (out_free)
                begin
                    state_next = srts_pkg::ST_IDLE;
                end
            end
            default:
            begin
                state_next = srts_pkg::ST_IDLE;
            end
        endcase
    end

    always_comb
    begin
        s_axis_tready = 1'b0;
        div_ctrl      = '0;
        stk_ctrl      = '0;
        out_load      = 1'b0;
        out_sym       = srts_pkg::CHAR_ZERO;
        out_last      = 1'b0;
        case (state_reg)
            srts_pkg::ST_IDLE:
            begin
                s_axis_tready = 1'b1;
                div_ctrl.load = s_axis_tvalid && alpha_ok && (in_value != '0);
            end
            srts_pkg::ST_DIV:
            begin
                stk_ctrl.push = div_stat.done;
                div_ctrl.cont = !div_stat.quo_zero;
            end
            srts_pkg::ST_SIGN:
            begin
                out_load = out_free;
                out_sym  = srts_pkg::CHAR_MINUS;
            end
            srts_pkg::ST_DIGITS:
            begin
                out_load     = out_free;
                stk_ctrl.pop = out_free;
                out_sym      = alphabet[stk_top*srts_pkg::SYM_W +: srts_pkg::SYM_W];
                out_last     = (stk_count == srts_pkg::STK_CNT_W'(1));
            end
            srts_pkg::ST_ZERO:
            begin
                out_load = out_free;
                out_last = 1'b1;
            end
            default:
            begin
                s_axis_tready = 1'b0;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= srts_pkg::ST_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (out_load)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (m_axis_tready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (out_load)
        begin
            out_sym_reg  <= out_sym;
            out_last_reg <= out_last;
        end
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = out_sym_reg;
    assign m_axis_tlast  = out_last_reg;

    // ---------------- assertions ----------------
    a_done_in_div: assert property (@(posedge clk) disable iff (!rst_n)
        div_stat.done |-> state_reg == srts_pkg::ST_DIV)
        else $error("divider finished outside of the division phase");

    a_stack_room: assert property (@(posedge clk) disable iff (!rst_n)
        stk_ctrl.push |-> stk_count < srts_pkg::STK_CNT_W'(srts_pkg::MAX_DIGITS))
        else $error("digit stack overflow");

    a_digits_present: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == srts_pkg::ST_DIGITS |-> stk_count != '0)
        else $error("digit output with an empty stack");

    a_bad_alpha_silent: assert property (@(posedge clk) disable iff (!rst_n)
        (in_xfer && !alpha_ok) |=> state_reg == srts_pkg::ST_IDLE && !stk_ctrl.push)
        else $error("value started with an invalid alphabet");

endmodule
